### rtl/core/apbod_pkg.sv
// ----------------------------------------------------------------------------
// apbod_pkg
// Shared widths, the stored box record and the controller command bundle
// for the all-pairs box overlap detector.
// ----------------------------------------------------------------------------
package apbod_pkg;

  // Default store depth
  localparam int MAX_BOXES_DEF = 64;

  // Field widths
  localparam int POS_W    = 24;
  localparam int PIV_W    = 10;
  localparam int SIZE_W   = 16;
  localparam int PROD_W   = PIV_W + SIZE_W + 1;
  localparam int CORNER_W = 25;
  localparam int END_W    = 26;
  localparam int OUT_IDX_W = 6;

  // Stream bus widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 16;

  // One stored box: lower-left corner and far edge on each axis
  typedef struct packed {
    logic signed [CORNER_W-1:0] cx;
    logic signed [END_W-1:0]    ex;
    logic signed [CORNER_W-1:0] cy;
    logic signed [END_W-1:0]    ey;
  } box_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 ld_en;    // store the accepted box
    logic [OUT_IDX_W-1:0] ld_idx;   // slot for the box
    logic                 sw_en;    // issue a sweep read
    logic                 sw_row;   // read is the row box i
    logic                 sw_last;  // read is the last partner j of the row
    logic [OUT_IDX_W-1:0] sw_idx;   // box read
    logic                 em_rd;    // read the result entry
    logic [OUT_IDX_W-1:0] em_idx;   // result entry read
    logic                 em_ld;    // load the output register
    logic                 em_last;  // result is the last of the frame
    logic                 clr;      // clear the hit flags
  } cmd_t;

endpackage

### rtl/core/apbod_ctrl.sv
// ----------------------------------------------------------------------------
// apbod_ctrl
// Frame sequencer: counts loaded boxes, walks the pair sweep row by row and
// steps the result emission.
// ----------------------------------------------------------------------------
module apbod_ctrl #(
  parameter int MAX_BOXES = apbod_pkg::MAX_BOXES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tlast,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output apbod_pkg::cmd_t cmd
);
  import apbod_pkg::*;

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_ELD   = 3'd6;
  localparam logic [2:0] S_EOUT  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic          drain_r, drain_nxt;
  logic          accept;
  logic          store;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] n_m2;
  logic          j_end;
  logic          k_end;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_EOUT);
  assign accept     = in_tvalid & in_tready;
  assign store      = accept & (cnt_r < CW'(MAX_BOXES));
  assign n_m1       = cnt_r - CW'(1);
  assign n_m2       = cnt_r - CW'(2);
  assign j_end      = (CW'(j_r) == n_m1);
  assign k_end      = (CW'(k_r) == n_m1);

  // Sequence the frame
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    cmd       = '0;
    cmd.ld_en  = store;
    cmd.ld_idx = OUT_IDX_W'(cnt_r[IW-1:0]);
    cmd.em_idx = OUT_IDX_W'(k_r);
    case (state_r)
      S_LOAD: begin
        if (store) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (accept && in_tlast) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end
      end
      // Let the last box reach the store
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          i_nxt = '0;
          k_nxt = '0;
          state_nxt = (cnt_r == CW'(1)) ? S_ERD : S_ROW;
        end
      end
      S_ROW: begin
        cmd.sw_en  = 1'b1;
        cmd.sw_row = 1'b1;
        cmd.sw_idx = OUT_IDX_W'(i_r);
        j_nxt      = i_r + IW'(1);
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cmd.sw_en   = 1'b1;
        cmd.sw_last = j_end;
        cmd.sw_idx  = OUT_IDX_W'(j_r);
        if (j_end) begin
          if (CW'(i_r) == n_m2) begin
            state_nxt = S_FLUSH;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_ROW;
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      // Let the final pair update the flags
      S_FLUSH: begin
        k_nxt     = '0;
        state_nxt = S_ERD;
      end
      S_ERD: begin
        cmd.em_rd = 1'b1;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        cmd.em_ld   = 1'b1;
        cmd.em_last = k_end;
        state_nxt   = S_EOUT;
      end
      S_EOUT: begin
        if (out_tready) begin
          if (k_end) begin
            cmd.clr   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

### rtl/core/apbod_dp.sv
// ----------------------------------------------------------------------------
// apbod_dp
// Datapath: corner computation pipeline, box store, pair overlap test,
// partner stores and the output register.
// ----------------------------------------------------------------------------
module apbod_dp #(
  parameter int MAX_BOXES = apbod_pkg::MAX_BOXES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  apbod_pkg::cmd_t                        cmd,
  input  logic signed [apbod_pkg::POS_W-1:0]     pos_x,
  input  logic signed [apbod_pkg::POS_W-1:0]     pos_y,
  input  logic signed [apbod_pkg::PIV_W-1:0]     pivot_x,
  input  logic signed [apbod_pkg::PIV_W-1:0]     pivot_y,
  input  logic        [apbod_pkg::SIZE_W-1:0]    size_x,
  input  logic        [apbod_pkg::SIZE_W-1:0]    size_y,
  output logic        [apbod_pkg::OUT_IDX_W-1:0] box_index,
  output logic                                   collided,
  output logic        [apbod_pkg::OUT_IDX_W-1:0] partner,
  output logic                                   last_result
);
  import apbod_pkg::*;

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  // Corner pipeline stage 1: products
  logic                     s1_vld_r;
  logic [IW-1:0]            s1_idx_r;
  logic signed [POS_W-1:0]  s1_px_r, s1_py_r;
  logic signed [PROD_W-1:0] s1_prx_r, s1_pry_r;
  logic [SIZE_W-1:0]        s1_sx_r, s1_sy_r;
  // Corner pipeline stage 2: corners
  logic                       s2_vld_r;
  logic [IW-1:0]              s2_idx_r;
  logic signed [CORNER_W-1:0] s2_cx_r, s2_cy_r;
  logic [SIZE_W-1:0]          s2_sx_r, s2_sy_r;
  box_t                       s2_box;

  // Stores
  box_t          box_mem [MAX_BOXES];
  logic [IW-1:0] fwd_mem [MAX_BOXES];
  logic [IW-1:0] back_mem [MAX_BOXES];
  logic [MAX_BOXES-1:0] fwd_hit_r;
  logic [MAX_BOXES-1:0] back_hit_r;

  // Sweep
  box_t          rd_box_r;
  logic          t_vld_r;
  logic          t_row_r;
  logic          t_last_r;
  logic [IW-1:0] t_idx_r;
  box_t          row_box_r;
  logic [IW-1:0] row_idx_r;
  logic [IW-1:0] best_r;
  logic          best_vld_r;
  logic          hit;
  logic signed [END_W-1:0] row_cx_e, row_cy_e, rd_cx_e, rd_cy_e;

  // Emission
  logic [IW-1:0] fwd_q_r, back_q_r, k_q_r;
  logic          fh_q_r, bh_q_r;
  logic [OUT_IDX_W-1:0] out_idx_r, out_partner_r;
  logic                 out_col_r, out_last_r;

  // Stage 1: register position and pivot * size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.ld_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      s1_idx_r <= cmd.ld_idx[IW-1:0];
      s1_px_r  <= pos_x;
      s1_py_r  <= pos_y;
      s1_prx_r <= pivot_x * $signed({1'b0, size_x});
      s1_pry_r <= pivot_y * $signed({1'b0, size_y});
      s1_sx_r  <= size_x;
      s1_sy_r  <= size_y;
    end
  end

  // Stage 2: corner = pos + floor(product / 256)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_idx_r <= s1_idx_r;
      s2_cx_r  <= {s1_px_r[POS_W-1], s1_px_r} +
                  {{6{s1_prx_r[PROD_W-1]}}, s1_prx_r[PROD_W-1:8]};
      s2_cy_r  <= {s1_py_r[POS_W-1], s1_py_r} +
                  {{6{s1_pry_r[PROD_W-1]}}, s1_pry_r[PROD_W-1:8]};
      s2_sx_r  <= s1_sx_r;
      s2_sy_r  <= s1_sy_r;
    end
  end

  // Stage 3: far edges, then write the store
  always_comb begin
    s2_box.cx = s2_cx_r;
    s2_box.cy = s2_cy_r;
    s2_box.ex = {s2_cx_r[CORNER_W-1], s2_cx_r} + {10'd0, s2_sx_r};
    s2_box.ey = {s2_cy_r[CORNER_W-1], s2_cy_r} + {10'd0, s2_sy_r};
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      box_mem[s2_idx_r] <= s2_box;
    end
    if (cmd.sw_en) begin
      rd_box_r <= box_mem[cmd.sw_idx[IW-1:0]];
    end
  end

  // Tag the sweep read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= cmd.sw_en;
    end
  end

  always_ff @(posedge clk) begin
    t_row_r  <= cmd.sw_row;
    t_last_r <= cmd.sw_last;
    t_idx_r  <= cmd.sw_idx[IW-1:0];
  end

  // Strict overlap of the row box and the box just read
  always_comb begin
    row_cx_e = {row_box_r.cx[CORNER_W-1], row_box_r.cx};
    row_cy_e = {row_box_r.cy[CORNER_W-1], row_box_r.cy};
    rd_cx_e  = {rd_box_r.cx[CORNER_W-1], rd_box_r.cx};
    rd_cy_e  = {rd_box_r.cy[CORNER_W-1], rd_box_r.cy};
    hit = t_vld_r && !t_row_r &&
          (row_cx_e < rd_box_r.ex) && (row_box_r.ex > rd_cx_e) &&
          (row_cy_e < rd_box_r.ey) && (row_box_r.ey > rd_cy_e);
  end

  // Hold the row box and track its largest partner
  always_ff @(posedge clk) begin
    if (t_vld_r && t_row_r) begin
      row_box_r <= rd_box_r;
      row_idx_r <= t_idx_r;
    end
    if (hit) begin
      best_r <= t_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (t_vld_r && t_row_r) begin
      best_vld_r <= 1'b0;
    end else if (hit) begin
      best_vld_r <= 1'b1;
    end
  end

  // Partner stores: later rows overwrite the backward partner
  always_ff @(posedge clk) begin
    if (hit) begin
      back_mem[t_idx_r] <= row_idx_r;
    end
    if (t_vld_r && !t_row_r && t_last_r && (hit || best_vld_r)) begin
      fwd_mem[row_idx_r] <= hit ? t_idx_r : best_r;
    end
    if (cmd.em_rd) begin
      fwd_q_r  <= fwd_mem[cmd.em_idx[IW-1:0]];
      back_q_r <= back_mem[cmd.em_idx[IW-1:0]];
      fh_q_r   <= fwd_hit_r[cmd.em_idx[IW-1:0]];
      bh_q_r   <= back_hit_r[cmd.em_idx[IW-1:0]];
      k_q_r    <= cmd.em_idx[IW-1:0];
    end
  end

  // Hit flags, cleared at frame end
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      fwd_hit_r  <= '0;
      back_hit_r <= '0;
    end else begin
      if (hit) begin
        back_hit_r[t_idx_r] <= 1'b1;
      end
      if (t_vld_r && !t_row_r && t_last_r && (hit || best_vld_r)) begin
        fwd_hit_r[row_idx_r] <= 1'b1;
      end
    end
  end

  // Output register: forward partner wins over backward partner
  always_ff @(posedge clk) begin
    if (cmd.em_ld) begin
      out_idx_r     <= OUT_IDX_W'(k_q_r);
      out_col_r     <= fh_q_r | bh_q_r;
      out_partner_r <= fh_q_r ? OUT_IDX_W'(fwd_q_r) :
                       bh_q_r ? OUT_IDX_W'(back_q_r) : '0;
      out_last_r    <= cmd.em_last;
    end
  end

  assign box_index   = out_idx_r;
  assign collided    = out_col_r;
  assign partner     = out_partner_r;
  assign last_result = out_last_r;

endmodule

### rtl/core/all_pairs_box_overlap_detector.sv
// ----------------------------------------------------------------------------
// all_pairs_box_overlap_detector
// Loads a frame of axis-aligned boxes, tests every pair for strict overlap
// and streams one collided flag and partner index per box.
// ----------------------------------------------------------------------------
// Boxes load one per cycle on the input stream; tlast marks the last box of
// a frame, and boxes beyond MAX_BOXES are dropped. Each box is stored as its
// corner pos + floor(pivot*size/256) and its far edge, through the product
// and corner registers. After the last box the input stalls: a drain state
// lets the last box reach the store, then the sweep reads the box store once
// per cycle, one read per row plus one per pair, then a flush state. The
// store's single read port serialises these reads. Results then leave in
// load order, one at a time, each through a partner store read, an output
// register load and the transfer, which waits while out_tready is low;
// tlast marks the last one, after which the next frame may load. The partner
// is the largest colliding later box, otherwise the largest colliding earlier
// box, and 0 when the box collides with nothing.
// ----------------------------------------------------------------------------
module all_pairs_box_overlap_detector #(
  parameter int MAX_BOXES = apbod_pkg::MAX_BOXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // pos_x[23:0], pos_y[47:24], pivot_x[57:48], pivot_y[67:58],
  // size_x[83:68], size_y[99:84], zero fill[103:100]
  input  logic [apbod_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                 in_tlast,   // last_box
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // box_index[5:0], collided[6], partner[12:7], zero fill[15:13]
  output logic [apbod_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tlast,  // last_result
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);
  import apbod_pkg::*;

  cmd_t                 cmd;
  logic [OUT_IDX_W-1:0] box_index;
  logic [OUT_IDX_W-1:0] partner;
  logic                 collided;

  apbod_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  apbod_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .pos_x       ($signed(in_tdata[23:0])),
    .pos_y       ($signed(in_tdata[47:24])),
    .pivot_x     ($signed(in_tdata[57:48])),
    .pivot_y     ($signed(in_tdata[67:58])),
    .size_x      (in_tdata[83:68]),
    .size_y      (in_tdata[99:84]),
    .box_index   (box_index),
    .collided    (collided),
    .partner     (partner),
    .last_result (out_tlast)
  );

  // Pack the result
  assign out_tdata = {3'b000, partner, collided, box_index};

endmodule
